/* hw/rtl/bmpu_pkg.sv */
// Shared types and constants for the BMP raster pixel unpacker.
// Holds the transfer payload structs, register indexes and pixel mode codes.
// No dependencies; every other file of the block refers to it by scoped names.
package bmpu_pkg;

    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int MAX_HEIGHT_DEF    = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;

    // Pixel mode codes held in the pixel_mode register.
    localparam logic [2:0] MODE_1BPP  = 3'd0;
    localparam logic [2:0] MODE_4BPP  = 3'd1;
    localparam logic [2:0] MODE_8BPP  = 3'd2;
    localparam logic [2:0] MODE_16BPP = 3'd3;
    localparam logic [2:0] MODE_24BPP = 3'd4;
    localparam logic [2:0] MODE_32BPP = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_PIXEL_MODE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Input item actions.
    localparam logic ACTION_PALETTE = 1'b0;
    localparam logic ACTION_RASTER  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] palette_index;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
        logic [7:0] raster_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [11:0] column;
        logic        last_of_run;
        logic        frame_done;
    } pixel_t;

    typedef struct packed {
        logic [2:0]  pixel_mode;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } cfg_t;

    // Work handed from the position tracker to the pixel sequencer.
    // A palette write carries its index in data_byte and its color in rgb.
    typedef struct packed {
        logic        is_write;
        logic [2:0]  mode;
        logic [7:0]  data_byte;
        logic [11:0] column;
        logic [3:0]  count;
        logic [23:0] rgb;
        logic [11:0] row;
        logic        frame_end;
    } job_t;

    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [7:0]  addr;
        logic [23:0] wdata;
    } pal_req_t;

endpackage

/* hw/rtl/bmpu_palette.sv */
// Palette memory: one write or one read per cycle, read data registered.
// Depends on bmpu_pkg for the request struct.
module bmpu_palette #(
    parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bmpu_pkg::pal_req_t req,
    output logic [23:0]        rdata
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [23:0] mem [PALETTE_DEPTH];
    logic [23:0] rdata_reg;
    logic        oob_reg;
    logic        oob_next;
    logic        in_range;

    assign in_range = ({1'b0, req.addr} < 9'(PALETTE_DEPTH));
    assign oob_next = req.rd_en ? !in_range : oob_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en && in_range)
        begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oob_reg <= 1'b0;
        end
        else
        begin
            oob_reg <= oob_next;
        end
    end

    // Indexes beyond the palette read as black.
    assign rdata = oob_reg ? 24'd0 : rdata_reg;

endmodule

/* hw/rtl/bmpu_track.sv */
// Raster position tracker: row, column and pitch counters and pixel assembly.
// Makes a job for each accepted palette entry and each accepted raster byte that yields pixels. Depends on bmpu_pkg.
module bmpu_track #(
    parameter int MAX_WIDTH  = bmpu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpu_pkg::MAX_HEIGHT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bmpu_pkg::cfg_t   cfg,
    input  logic             accept,
    input  bmpu_pkg::item_t  item,
    output logic             job_load,
    output bmpu_pkg::job_t   job
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = CW + 3;

    logic [PW-1:0] byte_in_row_reg,      byte_in_row_next;
    logic [RW-1:0] file_row_reg,         file_row_next;
    logic [CW-1:0] pixel_column_reg,     pixel_column_next;
    logic [15:0]   pixel_bytes_held_reg, pixel_bytes_held_next;
    logic [1:0]    byte_in_pixel_reg,    byte_in_pixel_next;

    logic [CW-1:0] w;
    logic [RW-1:0] h;
    logic [PW-1:0] row_bytes;
    logic [PW-1:0] pitch;
    logic [CW-1:0] remaining;
    logic [CW-1:0] column_sum;
    logic [3:0]    count;
    logic [23:0]   rgb;
    logic [7:0]    b;
    logic [15:0]   clr;
    logic          raster_ok;
    logic          row_end;
    logic          last_row;
    logic [11:0]   row_out;

    assign b         = item.raster_byte;
    assign raster_ok = (item.action == bmpu_pkg::ACTION_RASTER)
                       && (cfg.pixel_mode <= bmpu_pkg::MODE_32BPP);

    always_comb
    begin
        if (cfg.image_width == 13'd0)
            w = CW'(1);
        else if (32'(cfg.image_width) > MAX_WIDTH)
            w = CW'(MAX_WIDTH);
        else
            w = CW'(cfg.image_width);

        if (cfg.image_height == 13'd0)
            h = RW'(1);
        else if (32'(cfg.image_height) > MAX_HEIGHT)
            h = RW'(MAX_HEIGHT);
        else
            h = RW'(cfg.image_height);
    end

    always_comb
    begin
        unique case (cfg.pixel_mode)
            bmpu_pkg::MODE_1BPP:  row_bytes = (PW'(w) + PW'(7)) >> 3;
            bmpu_pkg::MODE_4BPP:  row_bytes = (PW'(w) + PW'(1)) >> 1;
            bmpu_pkg::MODE_8BPP:  row_bytes = PW'(w);
            bmpu_pkg::MODE_16BPP: row_bytes = PW'(w) << 1;
            bmpu_pkg::MODE_24BPP: row_bytes = PW'(w) + (PW'(w) << 1);
            bmpu_pkg::MODE_32BPP: row_bytes = PW'(w) << 2;
            default:              row_bytes = PW'(w);
        endcase
        pitch = (row_bytes + PW'(3)) & ~PW'(3);
    end

    always_comb
    begin
        count                 = 4'd0;
        rgb                   = 24'd0;
        pixel_bytes_held_next = pixel_bytes_held_reg;
        byte_in_pixel_next    = byte_in_pixel_reg;
        remaining             = w - pixel_column_reg;
        clr                   = {b, pixel_bytes_held_reg[7:0]};

        if (pixel_column_reg < w)
        begin
            unique case (cfg.pixel_mode)
                bmpu_pkg::MODE_1BPP:
                    count = (32'(remaining) >= 32'd8) ? 4'd8 : 4'(remaining);
                bmpu_pkg::MODE_4BPP:
                    count = (32'(remaining) >= 32'd2) ? 4'd2 : 4'd1;
                bmpu_pkg::MODE_8BPP:
                    count = 4'd1;
                bmpu_pkg::MODE_16BPP:
                begin
                    if (byte_in_pixel_reg == 2'd0)
                    begin
                        pixel_bytes_held_next = {8'd0, b};
                        byte_in_pixel_next    = 2'd1;
                    end
                    else
                    begin
                        count = 4'd1;
                        rgb   = {clr[14:10], 3'd0, clr[9:5], 3'd0, clr[4:0], 3'd0};
                        pixel_bytes_held_next = 16'd0;
                        byte_in_pixel_next    = 2'd0;
                    end
                end
                bmpu_pkg::MODE_24BPP, bmpu_pkg::MODE_32BPP:
                begin
                    if (byte_in_pixel_reg == 2'd0)
                    begin
                        pixel_bytes_held_next = pixel_bytes_held_reg | {8'd0, b};
                        byte_in_pixel_next    = 2'd1;
                    end
                    else if (byte_in_pixel_reg == 2'd1)
                    begin
                        pixel_bytes_held_next = pixel_bytes_held_reg | {b, 8'd0};
                        byte_in_pixel_next    = 2'd2;
                    end
                    else if (byte_in_pixel_reg == 2'd2
                             || cfg.pixel_mode == bmpu_pkg::MODE_24BPP)
                    begin
                        // File order is blue, green, red.
                        count = 4'd1;
                        rgb   = {b, pixel_bytes_held_reg[15:8], pixel_bytes_held_reg[7:0]};
                        pixel_bytes_held_next = 16'd0;
                        byte_in_pixel_next =
                            (cfg.pixel_mode == bmpu_pkg::MODE_32BPP) ? 2'd3 : 2'd0;
                    end
                    else
                    begin
                        // The fourth byte of a 32-bit pixel is dropped.
                        byte_in_pixel_next = 2'd0;
                    end
                end
                default:
                begin
                    count = 4'd0;
                end
            endcase
        end
        else if (cfg.pixel_mode == bmpu_pkg::MODE_32BPP && byte_in_pixel_reg == 2'd3)
        begin
            byte_in_pixel_next = 2'd0;
        end

        column_sum        = pixel_column_reg + CW'(count);
        pixel_column_next = column_sum;
        row_end = ((PW+1)'(byte_in_row_reg) + (PW+1)'(1)) >= (PW+1)'(pitch);
        file_row_next     = file_row_reg;
        byte_in_row_next  = byte_in_row_reg + PW'(1);

        if (row_end)
        begin
            byte_in_row_next      = PW'(0);
            pixel_column_next     = CW'(0);
            pixel_bytes_held_next = 16'd0;
            byte_in_pixel_next    = 2'd0;
            if (((RW+1)'(file_row_reg) + (RW+1)'(1)) >= (RW+1)'(h))
                file_row_next = RW'(0);
            else
                file_row_next = file_row_reg + RW'(1);
        end
    end

    assign last_row = (((RW+1)'(file_row_reg) + (RW+1)'(1)) == (RW+1)'(h));
    assign row_out  = (file_row_reg < h) ? 12'(h - RW'(1) - file_row_reg) : 12'd0;

    always_comb
    begin
        job           = '0;
        job.mode      = cfg.pixel_mode;
        job.column    = 12'(pixel_column_reg);
        job.count     = count;
        job.row       = row_out;
        job.frame_end = last_row && (column_sum == w);
        if (item.action == bmpu_pkg::ACTION_PALETTE)
        begin
            job.is_write  = 1'b1;
            job.data_byte = item.palette_index;
            job.rgb       = {item.palette_red, item.palette_green, item.palette_blue};
        end
        else
        begin
            job.data_byte = b;
            job.rgb       = rgb;
        end
    end

    assign job_load = accept && ((item.action == bmpu_pkg::ACTION_PALETTE)
                                 || (raster_ok && count != 4'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg      <= '0;
            file_row_reg         <= '0;
            pixel_column_reg     <= '0;
            pixel_bytes_held_reg <= '0;
            byte_in_pixel_reg    <= '0;
        end
        else if (accept && raster_ok)
        begin
            byte_in_row_reg      <= byte_in_row_next;
            file_row_reg         <= file_row_next;
            pixel_column_reg     <= pixel_column_next;
            pixel_bytes_held_reg <= pixel_bytes_held_next;
            byte_in_pixel_reg    <= byte_in_pixel_next;
        end
    end

endmodule

/* hw/rtl/bmpu_emit.sv */
// Pixel sequencer: steps through a job one pixel a cycle unless the output
// stalls, drives the palette port and holds the output register. Depends on bmpu_pkg.
module bmpu_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_load,
    input  bmpu_pkg::job_t     job,
    output logic               job_ready,
    output bmpu_pkg::pal_req_t pal_req,
    input  logic [23:0]        pal_rdata,
    output logic               pixel_valid,
    input  logic               pixel_ready,
    output bmpu_pkg::pixel_t   pixel
);

    logic             job_valid_reg, job_valid_next;
    bmpu_pkg::job_t   job_reg;
    logic [2:0]       step_reg, step_next;
    logic             out_valid_reg, out_valid_next;
    bmpu_pkg::pixel_t out_reg;
    logic             use_pal_reg;

    logic             advance;
    logic             issue;
    logic             issue_pixel;
    logic             last_step;
    logic             done;
    logic             use_pal;
    logic [7:0]       index;
    bmpu_pkg::pixel_t out_next;

    assign advance     = !out_valid_reg || pixel_ready;
    assign issue       = job_valid_reg && advance;
    assign issue_pixel = issue && !job_reg.is_write;
    assign last_step   = ({1'b0, step_reg} + 4'd1) == job_reg.count;
    assign done        = issue && (job_reg.is_write || last_step);
    assign job_ready   = !job_valid_reg || done;
    assign use_pal     = (job_reg.mode <= bmpu_pkg::MODE_8BPP);

    always_comb
    begin
        unique case (job_reg.mode)
            bmpu_pkg::MODE_1BPP: index = {7'd0, job_reg.data_byte[~step_reg]};
            bmpu_pkg::MODE_4BPP: index = (step_reg == 3'd0) ? {4'd0, job_reg.data_byte[7:4]}
                                                            : {4'd0, job_reg.data_byte[3:0]};
            default:             index = job_reg.data_byte;
        endcase
    end

    always_comb
    begin
        pal_req.wr_en = issue && job_reg.is_write;
        pal_req.rd_en = issue_pixel && use_pal;
        pal_req.addr  = job_reg.is_write ? job_reg.data_byte : index;
        pal_req.wdata = job_reg.rgb;
    end

    always_comb
    begin
        out_next.red         = job_reg.rgb[23:16];
        out_next.green       = job_reg.rgb[15:8];
        out_next.blue        = job_reg.rgb[7:0];
        out_next.row         = job_reg.row;
        out_next.column      = job_reg.column + 12'(step_reg);
        out_next.last_of_run = last_step;
        out_next.frame_done  = last_step && job_reg.frame_end;
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        step_next      = step_reg;
        if (job_load)
        begin
            job_valid_next = 1'b1;
            step_next      = 3'd0;
        end
        else if (done)
        begin
            job_valid_next = 1'b0;
            step_next      = 3'd0;
        end
        else if (issue)
        begin
            step_next = step_reg + 3'd1;
        end

        if (issue_pixel)
            out_valid_next = 1'b1;
        else if (pixel_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
        if (issue_pixel)
        begin
            out_reg     <= out_next;
            use_pal_reg <= use_pal;
        end
    end

    // Palette colors come straight from the memory's registered read port,
    // which holds its data while the output stalls.
    always_comb
    begin
        pixel = out_reg;
        if (use_pal_reg)
        begin
            pixel.red   = pal_rdata[23:16];
            pixel.green = pal_rdata[15:8];
            pixel.blue  = pal_rdata[7:0];
        end
    end

    assign pixel_valid = out_valid_reg;

endmodule

/* hw/rtl/bmp_raster_pixel_unpacker.sv */
// Top level of the BMP raster pixel unpacker: configuration registers and
// the tracker, sequencer and palette memory. Depends on bmpu_pkg and the
// bmpu_track, bmpu_emit and bmpu_palette modules.
//
//  Channel   Signals                          Moves per transfer
//  item      item_valid, item_ready, item     one palette entry or one raster byte
//  pixel     pixel_valid, pixel_ready, pixel  one RGB pixel with row and column
//  cfg       cfg_valid, cfg_ready, cfg_index, one register write (always ready)
//            cfg_data
//
// A raster byte makes up to eight pixels in 1bpp, up to two in 4bpp and at
// most one otherwise; bytes that make none load no job. The sequencer emits
// one pixel per cycle while the output is not stalled, and palette writes
// and lookups share the one port of the palette memory.
// Reset clears the counters and returns the configuration to 8bpp, one pixel
// by one row; the palette is not cleared.
// A stalled pixel transfer holds the sequencer, while one more item can
// still be taken into its job register.
module bmp_raster_pixel_unpacker #(
    parameter int MAX_WIDTH     = bmpu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = bmpu_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  bmpu_pkg::item_t  item,
    output logic             pixel_valid,
    input  logic             pixel_ready,
    output bmpu_pkg::pixel_t pixel,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [12:0]      cfg_data
);

    bmpu_pkg::cfg_t     cfg_reg, cfg_next;
    bmpu_pkg::job_t     job;
    bmpu_pkg::pal_req_t pal_req;
    logic               job_load;
    logic               item_accept;
    logic [23:0]        pal_rdata;

    // Configuration writes land whenever offered; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bmpu_pkg::REG_PIXEL_MODE:   cfg_next.pixel_mode   = cfg_data[2:0];
                bmpu_pkg::REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data;
                bmpu_pkg::REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_mode   <= bmpu_pkg::MODE_8BPP;
            cfg_reg.image_width  <= 13'd1;
            cfg_reg.image_height <= 13'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign item_accept = item_valid && item_ready;

    // The tracker updates all position state at the transfer itself, so the
    // next byte sees it at once; pixel generation runs behind it.
    bmpu_track #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (item_accept),
        .item     (item),
        .job_load (job_load),
        .job      (job)
    );

    bmpu_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_load    (job_load),
        .job         (job),
        .job_ready   (item_ready),
        .pal_req     (pal_req),
        .pal_rdata   (pal_rdata),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel)
    );

    // Palette writes and lookups share one port in job order, so a lookup
    // after a write always sees the new entry.
    bmpu_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pal_req),
        .rdata (pal_rdata)
    );

endmodule
